@@ sv/ase_pkg.sv @@
// Shared types and constants for the execute stage: instruction and result
// layouts, opcode, condition and command codes. No dependencies.
`default_nettype none

package ase_pkg;

  localparam int DATA_W     = 32;
  localparam int REG_COUNT  = 16;
  localparam int REG_IDX_W  = 4;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  localparam logic [REG_IDX_W-1:0] PC_REG = 4'd15;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_MUL    = 2'd1,
    CMD_BRANCH = 2'd2,
    CMD_HALT   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13
  } cond_t;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Decoded instruction, first packed field in the top bits.
  typedef struct packed {
    cmd_t              command;
    logic [31:0]       current_pc;
    logic [23:0]       operand_field;
    logic [3:0]        shift_reg;
    logic [3:0]        operand_reg;
    logic [3:0]        dest_reg;
    logic [3:0]        first_reg;
    logic              accumulate;
    logic              immediate_operand;
    logic              set_flags;
    logic [3:0]        alu_opcode;
    logic [3:0]        condition_code;
  } instr_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // One result beat, executed in the lowest bit.
  typedef struct packed {
    logic              status;
    logic              halted;
    logic              flush;
    flags_t            flag_bits;
    logic [31:0]       written_value;
    logic [3:0]        written_index;
    logic              wrote_register;
    logic              executed;
  } result_t;

  // Register operands read for one instruction.
  typedef struct packed {
    logic [DATA_W-1:0] rn_val;
    logic [DATA_W-1:0] rm_val;
    logic [DATA_W-1:0] rs_val;
  } operands_t;

  // Register file write request.
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
    logic [DATA_W-1:0]    data;
  } reg_write_t;

endpackage

`default_nettype wire

@@ sv/ase_ram.sv @@
// Generic single write port RAM with one registered read port.
// No package dependencies.
`default_nettype none

module ase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ase_shifter.sv @@
// Operand two generation: rotated immediate or barrel-shifted Rm with the
// shifter carry. Uses ase_pkg.
`default_nettype none

module ase_shifter (
  input  wire ase_pkg::instr_t    instr,
  input  wire ase_pkg::operands_t opnd,
  output      logic [31:0]        op2,
  output      logic               shift_carry
);

  logic [7:0]  amt;
  logic [4:0]  amt_lo;
  logic [3:0]  rot_field;
  logic [4:0]  rot;
  logic [7:0]  imm8;
  logic [63:0] imm_pair;
  logic [63:0] rm_pair;
  logic [32:0] lsl_wide;
  logic [32:0] lsr_wide;
  logic [32:0] asr_wide;
  logic [31:0] v;

  assign v         = opnd.rm_val;
  assign amt       = instr.operand_field[4] ? opnd.rs_val[7:0]
                                            : {3'b000, instr.operand_field[11:7]};
  assign amt_lo    = amt[4:0];
  assign rot_field = instr.operand_field[11:8];
  assign rot       = {rot_field, 1'b0};
  assign imm8      = instr.operand_field[7:0];
  assign imm_pair  = {24'd0, imm8, 24'd0, imm8} >> rot;
  assign rm_pair   = {v, v} >> amt_lo;
  assign lsl_wide  = {1'b0, v} << amt_lo;
  assign lsr_wide  = {v, 1'b0} >> amt_lo;
  assign asr_wide  = 33'($signed({v, 1'b0}) >>> amt_lo);

  // Select the shifted value and carry by shift kind and amount range.
  always_comb begin
    op2         = v;
    shift_carry = 1'b0;
    if (instr.immediate_operand) begin
      op2         = imm_pair[31:0];
      shift_carry = 1'b0;
    end else if (amt == 8'd0) begin
      op2         = v;
      shift_carry = 1'b0;
    end else begin
      case (ase_pkg::shift_t'(instr.operand_field[6:5]))
        ase_pkg::SH_LSL: begin
          if (amt < 8'd32) begin
            op2         = lsl_wide[31:0];
            shift_carry = lsl_wide[32];
          end else begin
            op2         = '0;
            shift_carry = (amt == 8'd32) ? v[0] : 1'b0;
          end
        end
        ase_pkg::SH_LSR: begin
          if (amt < 8'd32) begin
            op2         = lsr_wide[32:1];
            shift_carry = lsr_wide[0];
          end else begin
            op2         = '0;
            shift_carry = (amt == 8'd32) ? v[31] : 1'b0;
          end
        end
        ase_pkg::SH_ASR: begin
          if (amt < 8'd32) begin
            op2         = asr_wide[32:1];
            shift_carry = asr_wide[0];
          end else begin
            op2         = {32{v[31]}};
            shift_carry = v[31];
          end
        end
        default: begin
          // Rotate uses the amount modulo 32; the carry is the new top bit.
          op2         = rm_pair[31:0];
          shift_carry = rm_pair[31];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/ase_exec.sv @@
// Execute logic for one instruction: condition test, ALU, multiply, branch
// and halt, producing the result beat and the next architectural state.
// Uses ase_pkg and ase_shifter.
`default_nettype none

module ase_exec (
  input  wire ase_pkg::instr_t     instr,
  input  wire ase_pkg::operands_t  opnd,
  input  wire ase_pkg::flags_t     flags,
  input  wire logic                halt_latch,
  output      ase_pkg::result_t    res,
  output      ase_pkg::flags_t     flags_next,
  output      logic                halt_next,
  output      ase_pkg::reg_write_t wr
);

  logic [31:0] op2;
  logic        shift_carry;
  logic        cond_ok;
  logic [31:0] a;
  logic [32:0] add_wide;
  logic [31:0] alu_res;
  logic        alu_c;
  logic        alu_known;
  logic        alu_store;
  logic [31:0] mul_prod;
  logic [31:0] mul_res;
  logic [31:0] br_target;

  ase_shifter u_shifter (
    .instr       (instr),
    .opnd        (opnd),
    .op2         (op2),
    .shift_carry (shift_carry)
  );

  assign a         = opnd.rn_val;
  assign add_wide  = {1'b0, a} + {1'b0, op2};
  assign mul_prod  = 32'(opnd.rm_val * opnd.rs_val);
  assign mul_res   = mul_prod + (instr.accumulate ? opnd.rn_val : 32'd0);
  assign br_target = instr.current_pc
                   + {{6{instr.operand_field[23]}}, instr.operand_field, 2'b00};

  // Condition test against the current flags; C is never looked at.
  always_comb begin
    unique case (ase_pkg::cond_t'(instr.condition_code))
      ase_pkg::COND_EQ: cond_ok = flags.z;
      ase_pkg::COND_NE: cond_ok = !flags.z;
      ase_pkg::COND_GE: cond_ok = (flags.n == flags.v);
      ase_pkg::COND_LT: cond_ok = (flags.n != flags.v);
      ase_pkg::COND_GT: cond_ok = !flags.z && (flags.n == flags.v);
      ase_pkg::COND_LE: cond_ok = flags.z || (flags.n != flags.v);
      default:          cond_ok = 1'b1;
    endcase
  end

  // Data processing opcode decode.
  always_comb begin
    alu_res   = '0;
    alu_c     = shift_carry;
    alu_known = 1'b1;
    alu_store = 1'b1;
    unique case (ase_pkg::alu_op_t'(instr.alu_opcode))
      ase_pkg::OP_AND: alu_res = a & op2;
      ase_pkg::OP_EOR: alu_res = a ^ op2;
      ase_pkg::OP_SUB: begin
        alu_res = a - op2;
        alu_c   = (a >= op2);
      end
      ase_pkg::OP_RSB: begin
        alu_res = op2 - a;
        alu_c   = (op2 >= a);
      end
      ase_pkg::OP_ADD: begin
        alu_res = add_wide[31:0];
        alu_c   = add_wide[32];
      end
      ase_pkg::OP_TST: begin
        alu_res   = a & op2;
        alu_store = 1'b0;
      end
      ase_pkg::OP_TEQ: begin
        alu_res   = a ^ op2;
        alu_store = 1'b0;
      end
      ase_pkg::OP_CMP: begin
        alu_res   = a - op2;
        alu_c     = (a >= op2);
        alu_store = 1'b0;
      end
      ase_pkg::OP_ORR: alu_res = a | op2;
      ase_pkg::OP_MOV: alu_res = op2;
      default: begin
        alu_known = 1'b0;
        alu_store = 1'b0;
      end
    endcase
  end

  // Command selection and state update.
  always_comb begin
    res            = '0;
    flags_next     = flags;
    halt_next      = halt_latch;
    wr             = '0;
    if (halt_latch) begin
      // A halted core ignores everything.
    end else if (instr.command == ase_pkg::CMD_HALT) begin
      halt_next    = 1'b1;
      res.executed = 1'b1;
    end else if (cond_ok) begin
      unique case (instr.command)
        ase_pkg::CMD_DATA: begin
          if (!alu_known) begin
            res.status = 1'b1;
          end else begin
            res.executed = 1'b1;
            if (alu_store) begin
              wr.en   = 1'b1;
              wr.addr = instr.dest_reg;
              wr.data = alu_res;
            end
            if (instr.set_flags) begin
              flags_next = '{n: alu_res[31], z: (alu_res == 32'd0), c: alu_c, v: 1'b0};
            end
          end
        end
        ase_pkg::CMD_MUL: begin
          res.executed = 1'b1;
          wr.en        = 1'b1;
          wr.addr      = instr.dest_reg;
          wr.data      = mul_res;
          if (instr.set_flags) begin
            flags_next = '{n: mul_res[31], z: (mul_res == 32'd0), c: 1'b0, v: 1'b0};
          end
        end
        default: begin
          // Branch: PC-relative target into register 15 and flush.
          res.executed = 1'b1;
          res.flush    = 1'b1;
          wr.en        = 1'b1;
          wr.addr      = ase_pkg::PC_REG;
          wr.data      = br_target;
        end
      endcase
    end
    res.wrote_register = wr.en;
    res.written_index  = wr.addr;
    res.written_value  = wr.data;
    res.flag_bits      = flags_next;
    res.halted         = halt_next;
  end

endmodule

`default_nettype wire

@@ sv/arm_subset_execute_stage.sv @@
// Top level of the execute stage: input register, register file, execute
// logic and result register. Uses ase_pkg, ase_ram and ase_exec.
`default_nettype none

// The stage takes one decoded instruction per beat and can accept a new one
// every cycle while the result side does not stall. The register file read,
// registered when the instruction beat is accepted, forms the input stage,
// and the condition test, shifter, ALU or multiply then run as combinational
// logic into the result register, which holds the result beat. Results
// written by one instruction are forwarded to the next, so dependent
// instructions also issue back to back. A stall on the result side backs up
// through the input register into s_tready.
module arm_subset_execute_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // condition_code, alu_opcode, set_flags, immediate_operand, accumulate,
  // first_reg, dest_reg, operand_reg, shift_reg, operand_field, current_pc
  input  wire logic [ase_pkg::IN_DATA_W-1:0] s_tdata,
  // command
  input  wire logic [1:0]                    s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // executed, wrote_register, written_index, written_value, flag_bits,
  // flush, halted, status
  output      logic [ase_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int REG_COUNT = ase_pkg::REG_COUNT;
  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int INSTR_W = $bits(ase_pkg::instr_t);
  localparam int RES_W = $bits(ase_pkg::result_t);

  ase_pkg::instr_t     in_beat;
  ase_pkg::instr_t     instr;
  logic                in_valid;
  logic                accept;
  logic                advance;

  ase_pkg::flags_t     flags;
  ase_pkg::flags_t     flags_next;
  logic                halt_latch;
  logic                halt_next;
  ase_pkg::result_t    res_next;
  ase_pkg::result_t    result;
  logic                out_valid;
  ase_pkg::reg_write_t wr;
  logic                wr_en;

  logic [REG_COUNT-1:0] reg_valid;
  logic [31:0]          rn_ram;
  logic [31:0]          rm_ram;
  logic [31:0]          rs_ram;
  logic [31:0]          byp_data;
  logic                 rn_byp;
  logic                 rm_byp;
  logic                 rs_byp;
  logic                 rn_vld;
  logic                 rm_vld;
  logic                 rs_vld;
  ase_pkg::operands_t   opnd;

  assign in_beat = ase_pkg::instr_t'({s_tuser, s_tdata[INSTR_W-3:0]});

  // Handshake: the input register moves on when the result register is free.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = advance && wr.en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr <= in_beat;
    end
  end

  // Register file: three copies give the three read ports.
  ase_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rn (
    .clk (clk), .we (wr_en), .waddr (wr.addr[IDX_W-1:0]), .wdata (wr.data),
    .re (accept), .raddr (in_beat.first_reg[IDX_W-1:0]), .rdata (rn_ram)
  );
  ase_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rm (
    .clk (clk), .we (wr_en), .waddr (wr.addr[IDX_W-1:0]), .wdata (wr.data),
    .re (accept), .raddr (in_beat.operand_reg[IDX_W-1:0]), .rdata (rm_ram)
  );
  ase_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rs (
    .clk (clk), .we (wr_en), .waddr (wr.addr[IDX_W-1:0]), .wdata (wr.data),
    .re (accept), .raddr (in_beat.shift_reg[IDX_W-1:0]), .rdata (rs_ram)
  );

  // Valid bits make never-written registers read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_en) begin
      reg_valid[wr.addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Forwarding of a write that lands on the same edge as the read.
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data <= wr.data;
      rn_byp   <= wr_en && (wr.addr == in_beat.first_reg);
      rm_byp   <= wr_en && (wr.addr == in_beat.operand_reg);
      rs_byp   <= wr_en && (wr.addr == in_beat.shift_reg);
      rn_vld   <= reg_valid[in_beat.first_reg[IDX_W-1:0]];
      rm_vld   <= reg_valid[in_beat.operand_reg[IDX_W-1:0]];
      rs_vld   <= reg_valid[in_beat.shift_reg[IDX_W-1:0]];
    end
  end

  assign opnd.rn_val = rn_byp ? byp_data : (rn_vld ? rn_ram : 32'd0);
  assign opnd.rm_val = rm_byp ? byp_data : (rm_vld ? rm_ram : 32'd0);
  assign opnd.rs_val = rs_byp ? byp_data : (rs_vld ? rs_ram : 32'd0);

  ase_exec u_exec (
    .instr      (instr),
    .opnd       (opnd),
    .flags      (flags),
    .halt_latch (halt_latch),
    .res        (res_next),
    .flags_next (flags_next),
    .halt_next  (halt_next),
    .wr         (wr)
  );

  // Architectural flags and halt latch change when an instruction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      halt_latch <= 1'b0;
    end else if (advance) begin
      flags      <= flags_next;
      halt_latch <= halt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(ase_pkg::OUT_DATA_W - RES_W)'(0), result};

`ifndef SYNTH
  a_flush_writes_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.flush |-> result.wrote_register
      && (result.written_index == ase_pkg::PC_REG))
    else $error("flush without a write to the program counter");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt_latch |=> halt_latch)
    else $error("halt latch cleared without reset");

  a_status_no_effect: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status |-> !result.executed && !result.wrote_register)
    else $error("unknown opcode took effect");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire
